// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== design/i2cm_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
`default_nettype none
package i2cm_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_WRITE = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT = 2'd2;

   localparam logic [15:0] HOLD_TICKS_RST  = 16'd4;
   localparam logic [15:0] SETUP_TICKS_RST = 16'd5;
   localparam logic [23:0] ACK_TIMEOUT_RST = 24'd250000;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       ack_after_read;
      logic       scl_line;
      logic       sda_line;
   } item_type;

endpackage
`default_nettype wire

// ===== design/i2cm_if.sv =====
// Request and response channel interfaces.
`default_nettype none
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] data_byte;
   logic       ack_after_read;
   logic       scl_in;
   logic       sda_in;

   modport source (output valid, mode, data_byte, ack_after_read, scl_in, sda_in,
                   input ready);
   modport sink (input valid, mode, data_byte, ack_after_read, scl_in, sda_in,
                 output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_pull_low;
   logic       sda_pull_low;
   logic       busy_res;
   logic       done_res;
   logic       ack_seen;
   logic [7:0] read_byte;

   modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                   ack_seen, read_byte, input ready);
   modport sink (input valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                 ack_seen, read_byte, output ready);
endinterface
`default_nettype wire

// ===== design/i2cm_front.sv =====
// Front end: accepts request words and decodes the mode into a command.
`default_nettype none
module i2cm_front (
   i2cm_req_if.sink            req_bus,
   input  wire logic           queue_full,
   output i2cm_pkg::item_type  push_item,
   output logic                push_valid
);

   i2cm_pkg::cmd_type cmd;

   always_comb begin
      unique case (req_bus.mode)
         i2cm_pkg::MODE_START: cmd = i2cm_pkg::CMD_START;
         i2cm_pkg::MODE_STOP:  cmd = i2cm_pkg::CMD_STOP;
         i2cm_pkg::MODE_WRITE: cmd = i2cm_pkg::CMD_WRITE;
         i2cm_pkg::MODE_READ:  cmd = i2cm_pkg::CMD_READ;
         default:              cmd = i2cm_pkg::CMD_TICK;
      endcase
   end

   assign req_bus.ready            = !queue_full;
   assign push_valid               = req_bus.valid;
   assign push_item.cmd            = cmd;
   assign push_item.data_byte      = req_bus.data_byte;
   assign push_item.ack_after_read = req_bus.ack_after_read;
   assign push_item.scl_line       = req_bus.scl_in;
   assign push_item.sda_line       = req_bus.sda_in;

endmodule
`default_nettype wire

// ===== design/i2cm_queue.sv =====
// Short command queue between front end and bit engine.
`default_nettype none
`include "assert_macros.svh"
module i2cm_queue #(
   parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire i2cm_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop_ready,
   output logic                    pop_valid,
   output i2cm_pkg::item_type      pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   i2cm_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_NEVER(a_queue_overfill, clock, reset, count_ff > CNT_FULL)

endmodule
`default_nettype wire

// ===== design/i2cm_back.sv =====
// Bit engine: runs the bus state machine one queued word per cycle unless stalled.
`default_nettype none
`include "assert_macros.svh"
module i2cm_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [i2cm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [i2cm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              pop_valid,
   input  wire i2cm_pkg::item_type                pop_item,
   output logic                                   pop_ready,
   i2cm_rsp_if.source                             rsp_bus
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_WAIT, PH_ST_SETUP, PH_ST_HOLD1, PH_ST_HOLD2,
      PH_SP_HOLD, PH_SP_WAIT, PH_SP_END,
      PH_W_WAIT, PH_W_LOW, PH_W_ACK, PH_W_AWAIT, PH_W_AEND,
      PH_R_WAIT, PH_R_LOW, PH_R_AWAIT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] delay_ff, delay_in;
   logic [23:0] ack_wait_ff, ack_wait_in;
   logic        ack_flag_ff, ack_flag_in;
   logic        ack_choice_ff, ack_choice_in;
   logic        scl_drv_ff, scl_drv_in;
   logic        sda_drv_ff, sda_drv_in;

   logic [15:0] hold_ticks_ff, setup_ticks_ff;
   logic [23:0] ack_timeout_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_done_ff, rsp_ack_ff;
   logic        rsp_busy_ff;
   logic [7:0]  rsp_byte_ff;

   logic        pop, dly_exp, done_c, ack_c;
   logic [15:0] dly_next, hold_ld, setup_ld;
   logic [23:0] ack_inc, tmo;
   logic [3:0]  bit_inc;
   logic [7:0]  byte_c;

   assign pop       = pop_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign pop_ready = !rsp_valid_ff || rsp_bus.ready;
   assign dly_exp   = (delay_ff <= 16'd1);
   assign dly_next  = dly_exp ? 16'd0 : delay_ff - 16'd1;
   assign hold_ld   = (hold_ticks_ff == '0) ? 16'd1 : hold_ticks_ff;
   assign setup_ld  = (setup_ticks_ff == '0) ? 16'd1 : setup_ticks_ff;
   assign tmo       = (ack_timeout_ff == '0) ? 24'd1 : ack_timeout_ff;
   assign ack_inc   = ack_wait_ff + 24'd1;
   assign bit_inc   = bit_ff + 4'd1;

   always_comb begin
      phase_in      = phase_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      delay_in      = delay_ff;
      ack_wait_in   = ack_wait_ff;
      ack_flag_in   = ack_flag_ff;
      ack_choice_in = ack_choice_ff;
      scl_drv_in    = scl_drv_ff;
      sda_drv_in    = sda_drv_ff;
      done_c        = 1'b0;
      ack_c         = 1'b0;
      byte_c        = '0;
      if (pop) begin
         unique case (phase_ff)
            PH_IDLE: begin
               unique case (pop_item.cmd)
                  i2cm_pkg::CMD_START: begin
                     sda_drv_in = 1'b0;
                     scl_drv_in = 1'b0;
                     phase_in   = PH_ST_WAIT;
                  end
                  i2cm_pkg::CMD_STOP: begin
                     sda_drv_in = 1'b1;
                     delay_in   = hold_ld;
                     phase_in   = PH_SP_HOLD;
                  end
                  i2cm_pkg::CMD_WRITE: begin
                     shift_in   = pop_item.data_byte;
                     bit_in     = '0;
                     sda_drv_in = !pop_item.data_byte[7];
                     scl_drv_in = 1'b0;
                     phase_in   = PH_W_WAIT;
                  end
                  i2cm_pkg::CMD_READ: begin
                     shift_in      = '0;
                     bit_in        = '0;
                     ack_choice_in = pop_item.ack_after_read;
                     sda_drv_in    = 1'b0;
                     scl_drv_in    = 1'b0;
                     phase_in      = PH_R_WAIT;
                  end
                  default: ;
               endcase
            end
            PH_ST_WAIT: begin
               if (pop_item.scl_line) begin
                  delay_in = setup_ld;
                  phase_in = PH_ST_SETUP;
               end
            end
            PH_ST_SETUP: begin
               delay_in = dly_next;
               if (dly_exp) begin
                  sda_drv_in = 1'b1;
                  delay_in   = hold_ld;
                  phase_in   = PH_ST_HOLD1;
               end
            end
            PH_ST_HOLD1: begin
               delay_in = dly_next;
               if (dly_exp) begin
                  scl_drv_in = 1'b1;
                  delay_in   = hold_ld;
                  phase_in   = PH_ST_HOLD2;
               end
            end
            PH_ST_HOLD2: begin
               delay_in = dly_next;
               if (dly_exp) begin
                  done_c   = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            PH_SP_HOLD: begin
               delay_in = dly_next;
               if (dly_exp) begin
                  scl_drv_in = 1'b0;
                  phase_in   = PH_SP_WAIT;
               end
            end
            PH_SP_WAIT: begin
               if (pop_item.scl_line) begin
                  sda_drv_in = 1'b0;
                  delay_in   = hold_ld;
                  phase_in   = PH_SP_END;
               end
            end
            PH_SP_END: begin
               delay_in = dly_next;
               if (dly_exp) begin
                  done_c   = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            PH_W_WAIT: begin
               if (pop_item.scl_line) begin
                  scl_drv_in = 1'b1;
                  delay_in   = hold_ld;
                  phase_in   = PH_W_LOW;
               end
            end
            PH_W_LOW: begin
               delay_in = dly_next;
               if (dly_exp) begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in   = bit_inc;
                  if (bit_inc >= 4'd8) begin
                     sda_drv_in  = 1'b0;
                     scl_drv_in  = 1'b0;
                     ack_wait_in = '0;
                     ack_flag_in = 1'b0;
                     phase_in    = PH_W_ACK;
                  end else begin
                     sda_drv_in = !shift_ff[6];
                     scl_drv_in = 1'b0;
                     phase_in   = PH_W_WAIT;
                  end
               end
            end
            PH_W_ACK: begin
               if (!pop_item.sda_line) begin
                  ack_flag_in = 1'b1;
                  phase_in    = PH_W_AWAIT;
               end else begin
                  ack_wait_in = ack_inc;
                  if (ack_inc >= tmo || ack_inc == '0) begin
                     ack_flag_in = 1'b0;
                     phase_in    = PH_W_AWAIT;
                  end
               end
            end
            PH_W_AWAIT: begin
               if (pop_item.scl_line) begin
                  scl_drv_in = 1'b1;
                  delay_in   = hold_ld;
                  phase_in   = PH_W_AEND;
               end
            end
            PH_W_AEND: begin
               delay_in = dly_next;
               if (dly_exp) begin
                  done_c   = 1'b1;
                  ack_c    = ack_flag_ff;
                  phase_in = PH_IDLE;
               end
            end
            PH_R_WAIT: begin
               if (pop_item.scl_line) begin
                  shift_in   = {shift_ff[6:0], pop_item.sda_line};
                  scl_drv_in = 1'b1;
                  delay_in   = hold_ld;
                  phase_in   = PH_R_LOW;
               end
            end
            PH_R_LOW: begin
               delay_in = dly_next;
               if (dly_exp) begin
                  bit_in     = bit_inc;
                  scl_drv_in = 1'b0;
                  if (bit_inc >= 4'd8) begin
                     sda_drv_in = ack_choice_ff;
                     phase_in   = PH_R_AWAIT;
                  end else begin
                     phase_in = PH_R_WAIT;
                  end
               end
            end
            PH_R_AWAIT: begin
               if (pop_item.scl_line) begin
                  scl_drv_in = 1'b1;
                  done_c     = 1'b1;
                  byte_c     = shift_ff;
                  phase_in   = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_ff         <= '0;
         shift_ff       <= '0;
         delay_ff       <= '0;
         ack_wait_ff    <= '0;
         ack_flag_ff    <= 1'b0;
         ack_choice_ff  <= 1'b0;
         scl_drv_ff     <= 1'b0;
         sda_drv_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hold_ticks_ff  <= i2cm_pkg::HOLD_TICKS_RST;
         setup_ticks_ff <= i2cm_pkg::SETUP_TICKS_RST;
         ack_timeout_ff <= i2cm_pkg::ACK_TIMEOUT_RST;
      end else begin
         phase_ff      <= phase_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         delay_ff      <= delay_in;
         ack_wait_ff   <= ack_wait_in;
         ack_flag_ff   <= ack_flag_in;
         ack_choice_ff <= ack_choice_in;
         scl_drv_ff    <= scl_drv_in;
         sda_drv_ff    <= sda_drv_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               i2cm_pkg::CSR_HOLD_TICKS:  hold_ticks_ff  <= csr_wdata[15:0];
               i2cm_pkg::CSR_SETUP_TICKS: setup_ticks_ff <= csr_wdata[15:0];
               i2cm_pkg::CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata[23:0];
               default: ;
            endcase
         end
      end
      if (pop) begin
         rsp_busy_ff <= (phase_in != PH_IDLE);
         rsp_done_ff <= done_c;
         rsp_ack_ff  <= ack_c;
         rsp_byte_ff <= byte_c;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.scl_pull_low = scl_drv_ff;
   assign rsp_bus.sda_pull_low = sda_drv_ff;
   assign rsp_bus.busy_res     = rsp_busy_ff;
   assign rsp_bus.done_res     = rsp_done_ff;
   assign rsp_bus.ack_seen     = rsp_ack_ff;
   assign rsp_bus.read_byte    = rsp_byte_ff;

   `ASSERT_PROP(a_done_means_idle, clock, reset, rsp_valid_ff && rsp_done_ff |-> !rsp_busy_ff)
   `ASSERT_PROP(a_ack_needs_done, clock, reset, rsp_valid_ff && rsp_ack_ff |-> rsp_done_ff)
   `ASSERT_PROP(a_byte_needs_done, clock, reset, rsp_valid_ff && !rsp_done_ff |-> rsp_byte_ff == '0)
   `ASSERT_PROP(a_stall_freezes_fsm, clock, reset, rsp_valid_ff && !rsp_bus.ready |=> $stable(phase_ff))

endmodule
`default_nettype wire

// ===== design/i2c_master_bit_engine_core.sv =====
// I2C master bit engine: one request word per bus tick, one response word per request.
// Usage:
//   req_bus carries one word per timing tick: a mode (0 tick, 1 start, 2 stop,
//   3 write byte, 4 read byte; 5..7 act as tick), the write data, the ACK choice
//   for reads and the sampled SCL/SDA levels. Commands are taken only while idle.
//   rsp_bus returns one word per request: SCL/SDA pull-low drives, busy, a done
//   pulse, the write ACK and the read byte (both zero unless done).
//   csr_we/csr_index/csr_wdata write hold_ticks (0), setup_ticks (1) and
//   ack_timeout (2); write only while no request is in flight.
// Timing:
//   A response word is registered: an accepted request word is first written
//   into the queue, then the state machine's output register takes it when the
//   queue pops it. One word per cycle is sustained while the response port
//   accepts; the state machine advances once per word.
// Reset: state machine idle, both lines released, registers at 4, 5 and 250000,
//   queue empty.
// Stall: while the response port is held off the state machine freezes; the
//   queue takes up to QUEUE_DEPTH more words, then req_bus.ready drops.
`default_nettype none
module i2c_master_bit_engine_core #(
   parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   i2cm_req_if.sink                               req_bus,
   i2cm_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [i2cm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [i2cm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   i2cm_pkg::item_type push_item, pop_item;
   logic push_valid, queue_full, pop_valid, pop_ready;

   i2cm_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push_item  (push_item),
      .push_valid (push_valid)
   );

   i2cm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   i2cm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire
